@@ rtl/rgbc_pkg.sv @@
// Types and constants for the RGBC to HSL converter.
// Depends on nothing; used by rtl/rgbc_to_hsl_unit.sv.
`default_nettype none

package rgbc_pkg;

   localparam int QuoBits = 7;

   localparam logic [6:0] PctFull   = 7'd100;
   localparam logic [5:0] HueSixty  = 6'd60;
   localparam logic [8:0] HueFull   = 9'd360;
   localparam logic [8:0] HueGreen  = 9'd120;
   localparam logic [8:0] HueBlue   = 9'd240;
   localparam logic [7:0] SumFull   = 8'd200;
   localparam logic [6:0] LightHalf = 7'd50;

   typedef enum logic [1:0] {
      HUE_RED_POS,
      HUE_RED_NEG,
      HUE_GREEN,
      HUE_BLUE
   } hue_sel_type;

   typedef struct packed {
      logic [15:0] red_count;
      logic [15:0] green_count;
      logic [15:0] blue_count;
      logic [15:0] clear_count;
   } req_type;

   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] lightness;
      logic       zero_clear;
   } rsp_type;

   typedef struct packed {
      logic [22:0] rem;
      logic [6:0]  quo;
      logic        ovf;
   } pct_lane_type;

   typedef struct packed {
      logic                    zero;
      logic [15:0]             clear;
      pct_lane_type [2:0]      lane;
   } pct_stage_type;

   typedef struct packed {
      logic        zero;
      logic        grey;
      hue_sel_type sel;
      logic        neg;
      logic [12:0] hrem;
      logic [6:0]  hdiv;
      logic [6:0]  hquo;
      logic [13:0] srem;
      logic [7:0]  sdiv;
      logic [6:0]  squo;
      logic [6:0]  light;
   } hsl_stage_type;

endpackage

`default_nettype wire

@@ rtl/rgbc_to_hsl_unit.sv @@
// RGBC reading to integer HSL converter, fully pipelined.
// Depends on rtl/rgbc_pkg.sv.
//
// Usage: present one reading on req_data with req_valid; it is taken when
// req_ready is high. Each reading yields exactly one item on rsp_data,
// handed over when rsp_valid and rsp_ready are both high.
// A reading passes these registers in order: the accepting edge loads the
// colour*100 products, seven stages resolve the percentage quotients one
// bit each, one stage finds max/min and sets up hue and saturation, seven
// stages resolve both quotients one bit each, and the output register
// assembles the result. Throughput is one reading per cycle unless stalled.
// A clear count of zero gives zero_clear set and all other fields zero.
// Reset empties the pipeline; no result is pending after it.
// When the receiver stalls with a result held, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
`default_nettype none

module rgbc_to_hsl_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  rgbc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output rgbc_pkg::rsp_type rsp_data
);

   localparam int Steps = rgbc_pkg::QuoBits;

   logic adv;

   rgbc_pkg::pct_stage_type pa_ff [0:Steps];
   rgbc_pkg::pct_stage_type pa_in [0:Steps];
   logic                    pa_vld_ff [0:Steps];

   rgbc_pkg::hsl_stage_type hb_ff [0:Steps];
   rgbc_pkg::hsl_stage_type hb_in [0:Steps];
   logic                    hb_vld_ff [0:Steps];

   logic              rsp_valid_ff;
   rgbc_pkg::rsp_type rsp_data_ff;
   rgbc_pkg::rsp_type rsp_data_in;

   logic [2:0][15:0] cnt;
   logic [2:0][22:0] prod;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cnt = {req_data.blue_count, req_data.green_count, req_data.red_count};

   always_comb begin
      pa_in[0].zero  = (req_data.clear_count == 16'd0);
      pa_in[0].clear = req_data.clear_count;
      for (int i = 0; i < 3; i++) begin
         prod[i] = 23'(cnt[i]) * 23'(rgbc_pkg::PctFull);
         pa_in[0].lane[i].rem = prod[i];
         pa_in[0].lane[i].quo = '0;
         pa_in[0].lane[i].ovf = ({1'b0, prod[i]} >= {1'b0, req_data.clear_count, 7'd0});
      end
   end

   genvar k;
   generate
      for (k = 1; k <= Steps; k++) begin : g_pct
         localparam int Bit = Steps - k;
         logic [22:0] dsh;
         assign dsh = 23'(pa_ff[k-1].clear) << Bit;
         always_comb begin
            pa_in[k] = pa_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               if (pa_ff[k-1].lane[i].rem >= dsh) begin
                  pa_in[k].lane[i].rem      = pa_ff[k-1].lane[i].rem - dsh;
                  pa_in[k].lane[i].quo[Bit] = 1'b1;
               end
            end
         end
      end
   endgenerate

   generate
      for (k = 0; k <= Steps; k++) begin : g_pa_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               pa_vld_ff[k] <= 1'b0;
            end else if (adv) begin
               pa_vld_ff[k] <= (k == 0) ? req_valid : pa_vld_ff[k == 0 ? 0 : k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               pa_ff[k] <= pa_in[k];
            end
         end
      end
   endgenerate

   logic [2:0][6:0] pct;
   logic [6:0]      mx;
   logic [6:0]      mn;
   logic [6:0]      dif;
   logic [7:0]      sum;
   logic [6:0]      mag;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pa_ff[Steps].lane[i].ovf || pa_ff[Steps].lane[i].quo > rgbc_pkg::PctFull) begin
            pct[i] = rgbc_pkg::PctFull;
         end else begin
            pct[i] = pa_ff[Steps].lane[i].quo;
         end
      end
      mx = pct[0];
      if (pct[1] > mx) mx = pct[1];
      if (pct[2] > mx) mx = pct[2];
      mn = pct[0];
      if (pct[1] < mn) mn = pct[1];
      if (pct[2] < mn) mn = pct[2];
      dif = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};

      hb_in[0]       = '0;
      hb_in[0].zero  = pa_ff[Steps].zero;
      hb_in[0].grey  = (dif == 7'd0);
      hb_in[0].light = sum[7:1];
      hb_in[0].hdiv  = dif;
      hb_in[0].srem  = 14'(dif) * 14'(rgbc_pkg::PctFull);
      hb_in[0].sdiv  = (sum[7:1] <= rgbc_pkg::LightHalf) ? sum : rgbc_pkg::SumFull - sum;

      if (pct[0] == mx) begin
         hb_in[0].sel = (pct[1] < pct[2]) ? rgbc_pkg::HUE_RED_NEG : rgbc_pkg::HUE_RED_POS;
         hb_in[0].neg = (pct[1] < pct[2]);
         mag = (pct[1] >= pct[2]) ? pct[1] - pct[2] : pct[2] - pct[1];
      end else if (pct[1] == mx) begin
         hb_in[0].sel = rgbc_pkg::HUE_GREEN;
         hb_in[0].neg = (pct[2] < pct[0]);
         mag = (pct[2] >= pct[0]) ? pct[2] - pct[0] : pct[0] - pct[2];
      end else begin
         hb_in[0].sel = rgbc_pkg::HUE_BLUE;
         hb_in[0].neg = (pct[0] < pct[1]);
         mag = (pct[0] >= pct[1]) ? pct[0] - pct[1] : pct[1] - pct[0];
      end
      hb_in[0].hrem = 13'(mag) * 13'(rgbc_pkg::HueSixty);
   end

   generate
      for (k = 1; k <= Steps; k++) begin : g_hsl
         localparam int Bit = Steps - k;
         logic [12:0] hsh;
         logic [13:0] ssh;
         assign hsh = 13'(hb_ff[k-1].hdiv) << Bit;
         assign ssh = 14'(hb_ff[k-1].sdiv) << Bit;
         always_comb begin
            hb_in[k] = hb_ff[k-1];
            if (hb_ff[k-1].hrem >= hsh) begin
               hb_in[k].hrem      = hb_ff[k-1].hrem - hsh;
               hb_in[k].hquo[Bit] = 1'b1;
            end
            if (hb_ff[k-1].srem >= ssh) begin
               hb_in[k].srem      = hb_ff[k-1].srem - ssh;
               hb_in[k].squo[Bit] = 1'b1;
            end
         end
      end
   endgenerate

   generate
      for (k = 0; k <= Steps; k++) begin : g_hb_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               hb_vld_ff[k] <= 1'b0;
            end else if (adv) begin
               hb_vld_ff[k] <= (k == 0) ? pa_vld_ff[Steps] : hb_vld_ff[k == 0 ? 0 : k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               hb_ff[k] <= hb_in[k];
            end
         end
      end
   endgenerate

   logic [8:0] q9;

   always_comb begin
      q9          = 9'(hb_ff[Steps].hquo);
      rsp_data_in = '0;
      if (hb_ff[Steps].zero) begin
         rsp_data_in.zero_clear = 1'b1;
      end else begin
         rsp_data_in.lightness = hb_ff[Steps].light;
         if (!hb_ff[Steps].grey) begin
            rsp_data_in.saturation = hb_ff[Steps].squo;
            unique case (hb_ff[Steps].sel)
               rgbc_pkg::HUE_RED_POS: rsp_data_in.hue = q9;
               rgbc_pkg::HUE_RED_NEG: rsp_data_in.hue = (q9 == 9'd0) ? 9'd0 : rgbc_pkg::HueFull - q9;
               rgbc_pkg::HUE_GREEN:   rsp_data_in.hue = hb_ff[Steps].neg ?
                                         rgbc_pkg::HueGreen - q9 : rgbc_pkg::HueGreen + q9;
               default:               rsp_data_in.hue = hb_ff[Steps].neg ?
                                         rgbc_pkg::HueBlue - q9 : rgbc_pkg::HueBlue + q9;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= hb_vld_ff[Steps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.hue < rgbc_pkg::HueFull)
      else $error("hue out of range");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.saturation <= rgbc_pkg::PctFull &&
                     rsp_data.lightness <= rgbc_pkg::PctFull))
      else $error("percentage out of range");

   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_clear) |->
         (rsp_data.hue == 9'd0 && rsp_data.saturation == 7'd0 && rsp_data.lightness == 7'd0))
      else $error("zero clear item carries nonzero fields");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (hb_vld_ff[Steps] == $past(hb_vld_ff[Steps])))
      else $error("pipeline advanced during stall");

endmodule

`default_nettype wire

@@ test/tb_rgbc_to_hsl_unit.sv @@
// Self-checking testbench for rgbc_to_hsl_unit: RGBC readings in, integer HSL out.
// Depends on rtl/rgbc_pkg.sv and rtl/rgbc_to_hsl_unit.sv.
`timescale 1ns / 1ps
`default_nettype none

module tb_rgbc_to_hsl_unit;

   localparam int NumRandom  = 1000;
   localparam int StallLimit = 20000;
   localparam int NumRows    = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rgbc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rgbc_pkg::rsp_type rsp_data;

   rgbc_to_hsl_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   rgbc_pkg::rsp_type hsl_queue[$];
   int      errors = 0;
   int      sent = 0;
   int      received = 0;
   int      idle_cycles = 0;
   int      send_pct = 0;
   int      stall_pct = 0;
   bit      hold_off = 1'b0;

   typedef struct {
      rgbc_pkg::req_type rd;
      bit                known;
      rgbc_pkg::rsp_type hsl;
   } row_type;
   row_type rows[NumRows];

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pct_clamp(int unsigned colour, int unsigned clear);
      int unsigned p;
      p = (colour * 100) / clear;
      return (p > 100) ? 100 : int'(p);
   endfunction

   function automatic int quot_trunc(int num, int den);
      return (num >= 0) ? num / den : -((-num) / den);
   endfunction

   function automatic rgbc_pkg::rsp_type to_hsl(rgbc_pkg::req_type rd);
      rgbc_pkg::rsp_type o;
      int r, g, b, mx, mn, dif, sum, h, s, l;
      o = '0;
      if (rd.clear_count == 0) begin
         o.zero_clear = 1'b1;
         return o;
      end
      r = pct_clamp(rd.red_count, rd.clear_count);
      g = pct_clamp(rd.green_count, rd.clear_count);
      b = pct_clamp(rd.blue_count, rd.clear_count);
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      dif = mx - mn;
      sum = mx + mn;
      l = sum / 2;
      h = 0;
      s = 0;
      if (dif != 0) begin
         if (mx == r) begin
            h = quot_trunc(60 * (g - b), dif);
            if (g < b) begin
               h += 360;
               if (h >= 360) h -= 360;
            end
         end else if (mx == g) begin
            h = quot_trunc(60 * (b - r), dif) + 120;
         end else begin
            h = quot_trunc(60 * (r - g), dif) + 240;
         end
         s = (l <= 50) ? (dif * 100) / sum : (dif * 100) / (200 - sum);
      end
      o.hue = h[8:0];
      o.saturation = s[6:0];
      o.lightness = l[6:0];
      return o;
   endfunction

   function automatic row_type mk_row(int r, int g, int b, int c, bit known,
                                      int h, int s, int l, bit z);
      row_type t;
      t.rd = '{red_count: r[15:0], green_count: g[15:0], blue_count: b[15:0],
               clear_count: c[15:0]};
      t.known = known;
      t.hsl = '{hue: h[8:0], saturation: s[6:0], lightness: l[6:0], zero_clear: z};
      return t;
   endfunction

   function automatic rgbc_pkg::req_type rand_reading();
      rgbc_pkg::req_type rd;
      int unsigned c;
      case ($urandom_range(0, 9))
         0: c = 0;
         1: c = $urandom_range(1, 65535);
         2: c = $urandom_range(1, 8);
         default: c = $urandom_range(100, 20000);
      endcase
      rd.clear_count = c[15:0];
      if ($urandom_range(0, 4) == 0) begin
         rd.red_count   = 16'($urandom);
         rd.green_count = 16'($urandom);
         rd.blue_count  = 16'($urandom);
      end else begin
         rd.red_count   = 16'($urandom_range(0, c));
         rd.green_count = 16'($urandom_range(0, c));
         rd.blue_count  = 16'($urandom_range(0, c));
      end
      return rd;
   endfunction

   task automatic send_reading(rgbc_pkg::req_type rd);
      while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rd;
      do @(posedge clock); while (!req_ready);
      hsl_queue.push_back(to_hsl(rd));
      sent++;
   endtask

   always @(posedge clock) begin
      if (!reset)
         rsp_ready <= !hold_off && !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      rgbc_pkg::rsp_type exp_hsl;
      if (!reset && rsp_valid && rsp_ready) begin
         received++;
         if (hsl_queue.size() == 0) begin
            $error("unexpected item: %p", rsp_data);
            errors++;
         end else begin
            exp_hsl = hsl_queue.pop_front();
            if (rsp_data.hue !== exp_hsl.hue) begin
               $error("hue: expected %0d, got %0d", exp_hsl.hue, rsp_data.hue); errors++;
            end
            if (rsp_data.saturation !== exp_hsl.saturation) begin
               $error("saturation: expected %0d, got %0d", exp_hsl.saturation,
                      rsp_data.saturation); errors++;
            end
            if (rsp_data.lightness !== exp_hsl.lightness) begin
               $error("lightness: expected %0d, got %0d", exp_hsl.lightness,
                      rsp_data.lightness); errors++;
            end
            if (rsp_data.zero_clear !== exp_hsl.zero_clear) begin
               $error("zero_clear: expected %0d, got %0d", exp_hsl.zero_clear,
                      rsp_data.zero_clear); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      rows[0]  = mk_row(0, 0, 0, 0, 1, 0, 0, 0, 1);
      rows[1]  = mk_row(65535, 65535, 65535, 0, 1, 0, 0, 0, 1);
      rows[2]  = mk_row(0, 0, 0, 65535, 1, 0, 0, 0, 0);
      rows[3]  = mk_row(65535, 65535, 65535, 65535, 1, 0, 0, 100, 0);
      rows[4]  = mk_row(65535, 65535, 65535, 1, 1, 0, 0, 100, 0);
      rows[5]  = mk_row(100, 0, 0, 100, 1, 0, 100, 50, 0);
      rows[6]  = mk_row(0, 100, 0, 100, 1, 120, 100, 50, 0);
      rows[7]  = mk_row(0, 0, 100, 100, 1, 240, 100, 50, 0);
      rows[8]  = mk_row(50, 50, 50, 100, 1, 0, 0, 50, 0);
      rows[9]  = mk_row(100, 0, 1, 100, 0, 0, 0, 0, 0);
      rows[10] = mk_row(100, 0, 50, 100, 0, 0, 0, 0, 0);
      rows[11] = mk_row(100, 100, 0, 100, 0, 0, 0, 0, 0);
      rows[12] = mk_row(0, 100, 100, 100, 0, 0, 0, 0, 0);
      rows[13] = mk_row(100, 0, 100, 100, 0, 0, 0, 0, 0);
      rows[14] = mk_row(300, 200, 10, 100, 0, 0, 0, 0, 0);
      rows[15] = mk_row(90, 80, 70, 100, 0, 0, 0, 0, 0);
      rows[16] = mk_row(10, 20, 30, 100, 0, 0, 0, 0, 0);
      rows[17] = mk_row(21845, 43690, 65535, 65535, 0, 0, 0, 0, 0);
      rows[18] = mk_row(43690, 21845, 65535, 40000, 0, 0, 0, 0, 0);
      rows[19] = mk_row(1, 2, 3, 7, 0, 0, 0, 0, 0);
      for (int i = 0; i < NumRows; i++) begin
         if (rows[i].known && rows[i].hsl !== to_hsl(rows[i].rd)) begin
            $error("table row %0d: hue/sat/light expected %p, predictor %p",
                   i, rows[i].hsl, to_hsl(rows[i].rd));
            errors++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NumRows; i++) send_reading(rows[i].rd);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 70; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 70; end
            default: begin send_pct = 17; stall_pct = 17; end
         endcase
         if (p == 2) begin
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (60) @(posedge clock);
                  hold_off <= 1'b0;
               end
            join_none
         end
         for (int i = 0; i < NumRandom / 4; i++) send_reading(rand_reading());
      end
      req_valid <= 1'b0;

      send_pct = 0;
      stall_pct = 0;
      while (hsl_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("sent %0d readings, checked %0d results (zero clear, clamping, hue wrap,",
               sent, received);
      $display("ties, all lightness bands) under four idle/stall mixes");
      if (errors == 0 && received == sent) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

`default_nettype wire
